>>> hw/rtl/usfr_pkg.sv
// Shared types and constants for the sync/length frame receiver.
package usfr_pkg;

  localparam int          BUFFER_BYTES_DEF = 7;    // default frame buffer depth
  localparam int          LATCH_BYTES      = 7;    // bytes copied into the latch
  localparam logic [7:0]  SYNC_BYTE        = 8'h5A;
  localparam logic [8:0]  FRAME_EXTRA      = 9'd5; // header plus checksum bytes
  localparam logic [7:0]  CAPTURE_TYPE_RST = 8'h45;

  typedef enum logic [2:0] {
    ST_COLLECT  = 3'd0,
    ST_SYNC_ERR = 3'd1,
    ST_CAPTURED = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_ACK      = 3'd5
  } usfr_status_t;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_ACK  = 1'b1
  } usfr_kind_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } usfr_in_t;

  typedef struct packed {
    usfr_status_t status;
    logic [55:0]  frame_bytes;
    logic         frame_pending;
  } usfr_out_t;

endpackage

>>> hw/rtl/uart_sync_length_frame_receiver_core.sv
// Top level of the double-sync, length-framed serial byte receiver.
//
//   channel | ports                            | payload
//   --------+----------------------------------+-------------------------------
//   input   | in_valid  / in_ready  / in_data  | kind, rx_byte (usfr_in_t)
//   result  | out_valid / out_ready / out_data | status, frame_bytes,
//           |                                  | frame_pending (usfr_out_t)
//   config  | cfg_valid / cfg_ready / cfg_data | capture_type, 8 bits
//
// One transfer per cycle sustained while out_ready stays high; each item gives
// exactly one result after it is taken (input register, then the frame update
// into the result register). The frame update is the only logic between the two.
// Reset clears the index, buffer, latch, pending flag and sets capture_type
// to 0x45. A stalled result holds in the output register; the input
// register keeps taking items until both stages are full.
module uart_sync_length_frame_receiver_core #(
  parameter int BUFFER_BYTES = usfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  usfr_pkg::usfr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output usfr_pkg::usfr_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import usfr_pkg::*;

  logic      in_valid_r;
  usfr_in_t  in_data_r;
  logic      out_valid_r;
  usfr_out_t out_data_r;
  logic [7:0] capture_type_r;
  usfr_out_t result;
  logic      out_free;
  logic      stage_fire;

  // result register can take a new item when empty or draining this cycle
  assign out_free   = !out_valid_r || out_ready;
  assign stage_fire = in_valid_r && out_free;
  assign in_ready   = !in_valid_r || out_free;
  assign cfg_ready  = 1'b1;

  // configuration must land only while idle; the block does not enforce it, and keeps no ordering against items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capture_type_r <= CAPTURE_TYPE_RST;
    end else if (cfg_valid) begin
      capture_type_r <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (stage_fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  usfr_frame_engine #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (stage_fire),
    .item         (in_data_r),
    .capture_type (capture_type_r),
    .result       (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/usfr_frame_engine.sv
// Frame state (index, buffer, latch, pending) and its combinational next-state update.
module usfr_frame_engine #(
  parameter int BUFFER_BYTES = usfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  usfr_pkg::usfr_in_t item,
  input  logic [7:0]         capture_type,
  output usfr_pkg::usfr_out_t result
);
  import usfr_pkg::*;

  localparam int              IDX_W   = $clog2(BUFFER_BYTES);
  localparam logic [IDX_W:0]  BUF_CNT = (IDX_W + 1)'(BUFFER_BYTES);
  localparam logic [8:0]      BUF_CNT9 = 9'(BUFFER_BYTES);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       buf_r   [BUFFER_BYTES];
  logic [7:0]       buf_upd [BUFFER_BYTES];
  logic             pending_r, pending_nxt;
  logic [55:0]      latched_r, latched_nxt;
  logic [55:0]      gather;

  logic [IDX_W-1:0] pos;
  logic [IDX_W:0]   count;
  logic [8:0]       total;
  usfr_status_t     status;
  logic             byte_item;

  assign byte_item = (item.kind == KIND_BYTE);

  // out-of-range index restarts at entry 0
  assign pos   = ({1'b0, idx_r} >= BUF_CNT) ? '0 : idx_r;
  assign count = {1'b0, pos} + (IDX_W + 1)'(1);

  always_comb begin
    for (int k = 0; k < BUFFER_BYTES; k++) begin
      buf_upd[k] = (pos == IDX_W'(k)) ? item.rx_byte : buf_r[k];
    end
  end

  assign total = {1'b0, buf_upd[3]} + FRAME_EXTRA;

  // latch view: entries past the buffer read as zero
  for (genvar g = 0; g < LATCH_BYTES; g++) begin : g_gather
    if (g < BUFFER_BYTES) begin : g_have
      assign gather[8*g +: 8] = buf_upd[g];
    end else begin : g_none
      assign gather[8*g +: 8] = 8'h00;
    end
  end

  always_comb begin
    idx_nxt     = idx_r;
    pending_nxt = pending_r;
    latched_nxt = latched_r;
    status      = ST_COLLECT;
    if (!byte_item) begin
      pending_nxt = 1'b0;
      status      = ST_ACK;
    end else if ((pos == IDX_W'(0) || pos == IDX_W'(1)) && item.rx_byte != SYNC_BYTE) begin
      idx_nxt = '0;
      status  = ST_SYNC_ERR;
    end else if (count < (IDX_W + 1)'(4)) begin
      idx_nxt = count[IDX_W-1:0];
      status  = ST_COLLECT;
    end else if (total > BUF_CNT9) begin
      idx_nxt = '0;
      status  = ST_OVERFLOW;
    end else if (9'(count) != total) begin
      idx_nxt = count[IDX_W-1:0];
      status  = ST_COLLECT;
    end else begin
      idx_nxt = '0;
      if (buf_upd[2] == capture_type && !pending_r) begin
        latched_nxt = gather;
        pending_nxt = 1'b1;
        status      = ST_CAPTURED;
      end else begin
        status = ST_IGNORED;
      end
    end
  end

  assign result.status        = status;
  assign result.frame_bytes   = latched_nxt;
  assign result.frame_pending = pending_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      pending_r <= 1'b0;
      latched_r <= '0;
      for (int k = 0; k < BUFFER_BYTES; k++) begin
        buf_r[k] <= 8'h00;
      end
    end else if (fire) begin
      idx_r     <= idx_nxt;
      pending_r <= pending_nxt;
      latched_r <= latched_nxt;
      if (byte_item) begin
        for (int k = 0; k < BUFFER_BYTES; k++) begin
          buf_r[k] <= buf_upd[k];
        end
      end
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, idx_r} < BUF_CNT)
    else $error("frame index past buffer");

  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !byte_item |=> !pending_r)
    else $error("pending flag survived acknowledge");

  a_capture_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    fire && status == ST_CAPTURED |-> !pending_r)
    else $error("capture while a frame was pending");

  a_latch_only_on_capture: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && status == ST_CAPTURED) |=> $stable(latched_r))
    else $error("latched frame changed without capture");

endmodule

>>> test/testbench.sv
// Self-checking testbench for the double-sync, length-framed serial byte receiver.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import usfr_pkg::*;

  // Receiver geometry and run control
  localparam int BUF_DEPTH    = BUFFER_BYTES_DEF;
  localparam int PIPE_CYCLES  = 2;       // input register plus result register
  localparam int IDLE_PCT     = 12;      // chance per cycle that a side holds off
  localparam int RANDOM_ITEMS = 400;     // random items per capture_type setting
  localparam int CYCLE_LIMIT  = 200000;  // many times the slowest legal run
  localparam int PRINT_LIMIT  = 40;      // mismatch lines printed before going quiet

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  usfr_in_t   in_data;
  logic       out_valid;
  logic       out_ready;
  usfr_out_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  // quiet = 1 turns off all random hold-off on both sides
  bit quiet       = 1'b0;
  int items_sent  = 0;
  int mismatches  = 0;
  int cycles      = 0;

  // Shadow of the receiver state, advanced once per accepted input transfer
  logic [7:0]  match_type;
  int          rx_index;
  logic [7:0]  rx_buffer [BUF_DEPTH];
  logic        frame_held;
  logic [55:0] held_frame;

  // Results still owed by the block, oldest first
  usfr_out_t due_results [$];

  uart_sync_length_frame_receiver_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL uart_sync_length_frame_receiver_core");
      $finish;
    end
  end

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Result side: random back-pressure, changed only on the falling edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = !idle_now();
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT)
      $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Advance the shadow state by one item and return the result it must give.
  // Byte handling: store at the running index, check both sync bytes, then
  // use byte 3 as the payload length to find the end of the frame.
  function automatic usfr_out_t step_receiver(input usfr_in_t item);
    int           pos;
    int           count;
    int           total;
    usfr_status_t st;
    usfr_out_t    res;
    if (item.kind == KIND_ACK) begin
      // acknowledge always clears; the latched bytes stay visible
      frame_held = 1'b0;
      st = ST_ACK;
    end else begin
      pos = (rx_index >= BUF_DEPTH) ? 0 : rx_index;
      rx_buffer[pos] = item.rx_byte;
      count = pos + 1;
      if ((pos == 0 || pos == 1) && item.rx_byte != SYNC_BYTE) begin
        rx_index = 0;
        st = ST_SYNC_ERR;
      end else if (count < 4) begin
        rx_index = count;
        st = ST_COLLECT;
      end else begin
        total = int'(rx_buffer[3]) + int'(FRAME_EXTRA);
        if (total > BUF_DEPTH) begin
          // length would run past the buffer: frame dropped
          rx_index = 0;
          st = ST_OVERFLOW;
        end else if (count != total) begin
          rx_index = count;
          st = ST_COLLECT;
        end else begin
          rx_index = 0;
          if (rx_buffer[2] == match_type && !frame_held) begin
            // short frames pick up stale bytes from the upper entries
            held_frame = '0;
            for (int k = 0; k < LATCH_BYTES && k < BUF_DEPTH; k++)
              held_frame[8*k +: 8] = rx_buffer[k];
            frame_held = 1'b1;
            st = ST_CAPTURED;
          end else begin
            st = ST_IGNORED;
          end
        end
      end
    end
    res.status        = st;
    res.frame_bytes   = held_frame;
    res.frame_pending = frame_held;
    return res;
  endfunction

  // Result checker: every result transfer is matched against the oldest entry
  always @(posedge clk) begin : check_results
    usfr_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", out_data));
      end else begin
        want = due_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_data.status, want.status));
        if (out_data.frame_bytes !== want.frame_bytes)
          report_mismatch($sformatf("frame_bytes got %h want %h",
                                    out_data.frame_bytes, want.frame_bytes));
        if (out_data.frame_pending !== want.frame_pending)
          report_mismatch($sformatf("frame_pending got %b want %b",
                                    out_data.frame_pending, want.frame_pending));
      end
    end
  end

  // One input transfer: optional random gap, then hold valid until taken.
  // Valid stays high afterwards until the next falling edge decides.
  task automatic send_item(input usfr_kind_t kind, input logic [7:0] data);
    usfr_in_t item;
    item.kind    = kind;
    item.rx_byte = data;
    while (idle_now()) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    due_results.push_back(step_receiver(item));
    items_sent++;
  endtask

  // Full frame: two syncs, type, length, payload, checksum. An overrunning
  // length ends the frame at the length byte, so nothing follows it.
  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] len,
                            input bit with_acks);
    int n_bytes;
    n_bytes = (int'(len) + 5 > BUF_DEPTH) ? 4 : int'(len) + 5;
    for (int i = 0; i < n_bytes; i++) begin
      if (with_acks && $urandom_range(99) < 5)
        send_item(KIND_ACK, 8'($urandom));
      case (i)
        0, 1:    send_item(KIND_BYTE, SYNC_BYTE);
        2:       send_item(KIND_BYTE, ftype);
        3:       send_item(KIND_BYTE, len);
        default: send_item(KIND_BYTE, 8'($urandom));
      endcase
    end
  endtask

  // Let every owed result come back, then a little pipeline slack
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES + 2) @(posedge clk);
  endtask

  // capture_type is written only with the pipeline empty
  task automatic write_capture_type(input logic [7:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    match_type = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly well-formed frames with random content; the rest is acks,
  // overrunning lengths, broken second syncs and loose noise bytes.
  task automatic run_random_traffic(input int n_items);
    int stop_at;
    int pick;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_frame(($urandom_range(9) < 7) ? match_type : 8'($urandom),
                   8'($urandom_range(BUF_DEPTH - 5)), 1'b1);
      end else if (pick < 70) begin
        send_item(KIND_ACK, 8'($urandom));
      end else if (pick < 80) begin
        send_frame(8'($urandom), 8'($urandom_range(255, BUF_DEPTH - 4)), 1'b1);
      end else if (pick < 90) begin
        send_item(KIND_BYTE, SYNC_BYTE);
        send_item(KIND_BYTE, 8'($urandom));
      end else begin
        send_item(KIND_BYTE, 8'($urandom));
      end
    end
  endtask

  // Bad first sync at both byte extremes, bad second sync, idle acknowledge
  task automatic test_sync_errors();
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, 8'hFF);
    send_item(KIND_BYTE, SYNC_BYTE);
    send_item(KIND_BYTE, 8'h12);
    send_item(KIND_ACK, 8'hFF);
  endtask

  // Longest legal frame is latched; a second match while pending is dropped
  task automatic test_capture_and_busy();
    send_frame(CAPTURE_TYPE_RST, 8'(BUF_DEPTH - 5), 1'b0);
    send_frame(CAPTURE_TYPE_RST, 8'h00, 1'b0);
    send_item(KIND_ACK, 8'h00);
  endtask

  // Zero-length frame latches stale upper bytes; maximum length overruns
  task automatic test_short_frame_and_overflow();
    send_frame(CAPTURE_TYPE_RST, 8'h00, 1'b0);
    send_frame(CAPTURE_TYPE_RST, 8'hFF, 1'b0);
  endtask

  // Random traffic under both extremes of capture_type and a random value
  task automatic test_capture_type_sweep();
    write_capture_type(8'h00);
    run_random_traffic(RANDOM_ITEMS);
    write_capture_type(8'hFF);
    run_random_traffic(RANDOM_ITEMS);
    write_capture_type(8'($urandom));
    run_random_traffic(RANDOM_ITEMS);
  endtask

  // Back-to-back transfers on both sides for a long stretch
  task automatic test_no_idle_stretch();
    quiet = 1'b1;
    write_capture_type(CAPTURE_TYPE_RST);
    run_random_traffic(RANDOM_ITEMS);
    quiet = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;

    match_type = CAPTURE_TYPE_RST;
    rx_index   = 0;
    frame_held = 1'b0;
    held_frame = '0;
    foreach (rx_buffer[i]) rx_buffer[i] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_sync_errors();
    test_capture_and_busy();
    test_short_frame_and_overflow();
    test_capture_type_sweep();
    test_no_idle_stretch();

    drain_results();
    if (mismatches == 0) begin
      $display("PASS uart_sync_length_frame_receiver_core");
    end else begin
      $display("FAIL uart_sync_length_frame_receiver_core");
    end
    $finish;
  end

endmodule
